// ===== design/fpdf_pkg.sv =====
// ----------------------------------------------------------------------------
// fpdf_pkg
// Shared types and constants for the fixed-point decimal formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

    // raw value and BCD row sizing
    localparam int VALUE_W   = 64;
    localparam int NUM_BCD   = 20;
    localparam int BCD_IDX_W = $clog2(NUM_BCD);
    localparam int CNT_W     = $clog2(NUM_BCD + 1);
    localparam int STEP_W    = $clog2(VALUE_W);

    // character and register field widths
    localparam int CODE_W     = 16;
    localparam int FIELD_W    = 5;
    localparam int MODE_W     = 3;
    localparam int THRESH_W   = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // clamps
    localparam int MAX_EXPONENT    = 19;
    localparam int MAX_FRAC_DIGITS = 18;

    // parameter defaults
    localparam int DEF_MAX_INT_DIGITS = 20;
    localparam int DEF_CHAR_BITS      = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_EXP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAC_DIGIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH     = 3'd7;

    // mode bit positions
    localparam int MODE_PLUS         = 0;
    localparam int MODE_FORCE_PERIOD = 1;
    localparam int MODE_FORCE_FRAC   = 2;

    // register reset values
    localparam logic [FIELD_W-1:0] RST_MIN_INT   = 5'd1;
    localparam logic [CODE_W-1:0]  RST_SEP_CHAR  = 16'h00A0;
    localparam logic [CODE_W-1:0]  RST_PERIOD    = 16'h002E;
    localparam logic [MODE_W-1:0]  RST_MODE      = 3'd4;

    // character codes
    localparam logic [CODE_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CODE_W-1:0] CH_MINUS = 16'h002D;
    localparam logic [CODE_W-1:0] CH_PLUS  = 16'h002B;

    typedef logic [3:0] t_digit;
    typedef logic [NUM_BCD-1:0][3:0] t_digits;

    // control broadcast along the BCD row
    typedef struct packed {
        logic clear;
        logic shift;
        logic bit_in;
    } t_chain_ctl;

endpackage

// ===== design/fixed_point_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter
// After start is taken, the 64-bit magnitude is shifted MSB first through
//   the BCD cell row, a setup step follows, then IW remainder steps for the
//   group phase (IW = 5 at default parameters), then one character per
//   cycle on the output, N characters per item (0..59). Busy from start
//   until the last character is out; no new item is taken while busy.
// Reset: synchronous active low; registers return to their documented
//   values, no item in flight. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter #(
    parameter int MAX_INT_DIGITS = fpdf_pkg::DEF_MAX_INT_DIGITS,
    parameter int CHAR_BITS      = fpdf_pkg::DEF_CHAR_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [fpdf_pkg::VALUE_W-1:0]  i_value,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fpdf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpdf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_strobe,
    output logic [CHAR_BITS-1:0]                 o_char_code,
    output logic                                 o_last
);

    localparam int TOT_MAX = (MAX_INT_DIGITS > fpdf_pkg::NUM_BCD) ?
                             MAX_INT_DIGITS : fpdf_pkg::NUM_BCD;
    localparam int IW  = $clog2(TOT_MAX + 1);
    localparam int MCW = $clog2(IW + 1);
    localparam int VW  = fpdf_pkg::VALUE_W;
    localparam int FW  = fpdf_pkg::FIELD_W;
    localparam int CW  = fpdf_pkg::CODE_W;
    localparam int TW  = fpdf_pkg::THRESH_W;

    // state codes
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CONV   = 4'd1;
    localparam logic [3:0] S_PREP   = 4'd2;
    localparam logic [3:0] S_MOD    = 4'd3;
    localparam logic [3:0] S_SIGN   = 4'd4;
    localparam logic [3:0] S_INT    = 4'd5;
    localparam logic [3:0] S_SEP    = 4'd6;
    localparam logic [3:0] S_PERIOD = 4'd7;
    localparam logic [3:0] S_FRAC   = 4'd8;

    // configuration registers
    logic [FW-1:0]                r_scale_exp;
    logic [FW-1:0]                r_frac_digits;
    logic [FW-1:0]                r_min_int;
    logic [FW-1:0]                r_group;
    logic [CW-1:0]                r_sep_char;
    logic [CW-1:0]                r_period_char;
    logic [fpdf_pkg::MODE_W-1:0]  r_mode;
    logic [TW-1:0]                r_thresh;

    // sequencing
    logic [3:0]                   r_state, n_state;
    logic [VW-1:0]                r_shift, n_shift;
    logic                         r_neg, n_neg;
    logic [fpdf_pkg::STEP_W-1:0]  r_step, n_step;
    logic                         r_thr_ok, n_thr_ok;
    logic [fpdf_pkg::CNT_W-1:0]   r_n, n_n;
    logic [IW-1:0]                r_total, n_total;
    logic                         r_has_sign, n_has_sign;
    logic                         r_has_frac, n_has_frac;
    logic [IW:0]                  r_rem, n_rem;
    logic [IW-1:0]                r_mod_x, n_mod_x;
    logic [MCW-1:0]               r_mod_cnt, n_mod_cnt;
    logic [IW-1:0]                r_i, n_i;
    logic [IW-1:0]                r_g, n_g;
    logic [FW-1:0]                r_k, n_k;

    // output register
    logic                         r_strobe, n_strobe;
    logic [CW-1:0]                r_char, n_char;
    logic                         r_last, n_last;

    logic                         w_accept;
    logic                         w_cfg_wr;
    logic [VW-1:0]                w_raw;
    logic [VW-1:0]                w_mag;
    fpdf_pkg::t_chain_ctl         w_ctl;
    fpdf_pkg::t_digits            w_digits;
    logic [FW-1:0]                w_e;
    logic [FW-1:0]                w_fd;
    logic [IW-1:0]                w_mind;
    logic [fpdf_pkg::CNT_W-1:0]   w_ndig;
    logic [fpdf_pkg::CNT_W-1:0]   w_nint;
    logic [IW-1:0]                w_total;
    logic                         w_frac_nz;
    logic                         w_has_frac;
    logic [IW:0]                  w_int_sum;
    logic [fpdf_pkg::BCD_IDX_W-1:0] w_frac_idx;
    logic [fpdf_pkg::BCD_IDX_W-1:0] w_rd_idx;
    fpdf_pkg::t_digit             w_rd_digit;
    logic [CW-1:0]                w_int_char;
    logic [CW-1:0]                w_frac_char;
    logic [IW:0]                  w_trial;
    logic [IW:0]                  w_rem_next;
    logic [3:0]                   w_first_phase;
    logic [CHAR_BITS+CW-1:0]      w_code_ext;

    assign busy        = (r_state != S_IDLE) || !i_rst_n;
    assign o_cfg_ready = !busy;
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // magnitude, most negative value maps to 2^63
    assign w_raw = $unsigned(i_value);
    assign w_mag = w_raw[VW-1] ? (~w_raw + {{(VW-1){1'b0}}, 1'b1}) : w_raw;

    // BCD row control
    always_comb begin
        w_ctl.clear  = w_accept;
        w_ctl.shift  = (r_state == S_CONV);
        w_ctl.bit_in = r_shift[VW-1];
    end

    fpdf_bcd_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .o_digits (w_digits)
    );

    // clamped configuration
    assign w_e  = (r_scale_exp > FW'(fpdf_pkg::MAX_EXPONENT)) ?
                  FW'(fpdf_pkg::MAX_EXPONENT) : r_scale_exp;
    assign w_fd = (r_frac_digits > FW'(fpdf_pkg::MAX_FRAC_DIGITS)) ?
                  FW'(fpdf_pkg::MAX_FRAC_DIGITS) : r_frac_digits;
    assign w_mind = (32'(r_min_int) > MAX_INT_DIGITS) ?
                    IW'(MAX_INT_DIGITS) : IW'(r_min_int);

    // digit count of the magnitude and nonzero test of the fraction digits
    always_comb begin
        w_ndig    = '0;
        w_frac_nz = 1'b0;
        for (int k = 0; k < fpdf_pkg::NUM_BCD; k++) begin
            if (w_digits[k] != 4'd0) begin
                w_ndig = fpdf_pkg::CNT_W'(k + 1);
                if (k < int'(w_e)) begin
                    w_frac_nz = 1'b1;
                end
            end
        end
    end

    assign w_nint  = (w_ndig > fpdf_pkg::CNT_W'(w_e)) ?
                     w_ndig - fpdf_pkg::CNT_W'(w_e) : '0;
    assign w_total = (IW'(w_nint) > w_mind) ? IW'(w_nint) : w_mind;
    assign w_has_frac = ((w_fd != '0) || r_mode[fpdf_pkg::MODE_FORCE_PERIOD]) &&
                        r_thr_ok &&
                        (r_mode[fpdf_pkg::MODE_FORCE_FRAC] || w_frac_nz);

    // digit read: integer position i sits at i + e, fraction k at e - 1 - k
    assign w_int_sum  = (IW+1)'(r_i) + (IW+1)'(w_e);
    assign w_frac_idx = fpdf_pkg::BCD_IDX_W'(w_e - 5'd1 - r_k);
    assign w_rd_idx   = (r_state == S_FRAC) ? w_frac_idx :
                        w_int_sum[fpdf_pkg::BCD_IDX_W-1:0];
    assign w_rd_digit = w_digits[w_rd_idx];

    assign w_int_char  = (r_i < IW'(r_n)) ?
                         fpdf_pkg::CH_ZERO + CW'(w_rd_digit) : fpdf_pkg::CH_ZERO;
    assign w_frac_char = (r_k < w_e) ?
                         fpdf_pkg::CH_ZERO + CW'(w_rd_digit) : fpdf_pkg::CH_ZERO;

    // restoring remainder step: (total - 1) mod group_size
    assign w_trial    = {r_rem[IW-1:0], r_mod_x[IW-1]};
    assign w_rem_next = (w_trial >= (IW+1)'(r_group)) ?
                        w_trial - (IW+1)'(r_group) : w_trial;

    // first output phase after setup
    always_comb begin
        if (r_has_sign) begin
            w_first_phase = S_SIGN;
        end else if (r_total != '0) begin
            w_first_phase = S_INT;
        end else if (r_has_frac) begin
            w_first_phase = S_PERIOD;
        end else begin
            w_first_phase = S_IDLE;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_shift    = r_shift;
        n_neg      = r_neg;
        n_step     = r_step;
        n_thr_ok   = r_thr_ok;
        n_n        = r_n;
        n_total    = r_total;
        n_has_sign = r_has_sign;
        n_has_frac = r_has_frac;
        n_rem      = r_rem;
        n_mod_x    = r_mod_x;
        n_mod_cnt  = r_mod_cnt;
        n_i        = r_i;
        n_g        = r_g;
        n_k        = r_k;
        n_strobe   = 1'b0;
        n_char     = r_char;
        n_last     = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_shift = w_mag;
                    n_neg   = w_raw[VW-1];
                    n_step  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                // threshold test on the unshifted magnitude
                if (r_step == '0) begin
                    n_thr_ok = (r_thresh == '0) ||
                               ((r_shift[VW-1:TW] == '0) && (r_shift[TW-1:0] < r_thresh));
                end
                n_shift = {r_shift[VW-2:0], 1'b0};
                n_step  = r_step + 1'b1;
                if (r_step == '1) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_n        = w_nint;
                n_total    = w_total;
                n_has_sign = r_neg || r_mode[fpdf_pkg::MODE_PLUS];
                n_has_frac = w_has_frac;
                n_rem      = '0;
                n_mod_x    = w_total - 1'b1;
                n_mod_cnt  = '0;
                n_state    = S_MOD;
            end
            S_MOD: begin
                n_rem     = w_rem_next;
                n_mod_x   = {r_mod_x[IW-2:0], 1'b0};
                n_mod_cnt = r_mod_cnt + 1'b1;
                if (r_mod_cnt == MCW'(IW - 1)) begin
                    n_g     = w_rem_next[IW-1:0];
                    n_i     = r_total - 1'b1;
                    n_state = w_first_phase;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = r_neg ? fpdf_pkg::CH_MINUS : fpdf_pkg::CH_PLUS;
                n_last   = (r_total == '0) && !r_has_frac;
                if (r_total != '0) begin
                    n_state = S_INT;
                end else if (r_has_frac) begin
                    n_state = S_PERIOD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_INT: begin
                n_strobe = 1'b1;
                n_char   = w_int_char;
                n_last   = (r_i == '0) && !r_has_frac;
                if (r_i == '0) begin
                    n_state = r_has_frac ? S_PERIOD : S_IDLE;
                end else begin
                    n_i = r_i - 1'b1;
                    n_g = (r_g == '0) ? IW'(r_group) - 1'b1 : r_g - 1'b1;
                    // separator after a position that is a multiple of the group
                    if ((r_group != '0) && (r_g == '0)) begin
                        n_state = S_SEP;
                    end
                end
            end
            S_SEP: begin
                n_strobe = 1'b1;
                n_char   = r_sep_char;
                n_last   = 1'b0;
                n_state  = S_INT;
            end
            S_PERIOD: begin
                n_strobe = 1'b1;
                n_char   = r_period_char;
                n_last   = (w_fd == '0);
                n_k      = '0;
                n_state  = (w_fd == '0) ? S_IDLE : S_FRAC;
            end
            S_FRAC: begin
                n_strobe = 1'b1;
                n_char   = w_frac_char;
                n_last   = (r_k == w_fd - 5'd1);
                n_k      = r_k + 5'd1;
                if (r_k == w_fd - 5'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_neg      <= n_neg;
        r_step     <= n_step;
        r_thr_ok   <= n_thr_ok;
        r_n        <= n_n;
        r_total    <= n_total;
        r_has_sign <= n_has_sign;
        r_has_frac <= n_has_frac;
        r_rem      <= n_rem;
        r_mod_x    <= n_mod_x;
        r_mod_cnt  <= n_mod_cnt;
        r_i        <= n_i;
        r_g        <= n_g;
        r_k        <= n_k;
        r_char     <= n_char;
        r_last     <= n_last;
    end

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_exp   <= '0;
            r_frac_digits <= '0;
            r_min_int     <= fpdf_pkg::RST_MIN_INT;
            r_group       <= '0;
            r_sep_char    <= fpdf_pkg::RST_SEP_CHAR;
            r_period_char <= fpdf_pkg::RST_PERIOD;
            r_mode        <= fpdf_pkg::RST_MODE;
            r_thresh      <= '0;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                fpdf_pkg::REG_SCALE_EXP:  r_scale_exp   <= i_cfg_data[FW-1:0];
                fpdf_pkg::REG_FRAC_DIGIT: r_frac_digits <= i_cfg_data[FW-1:0];
                fpdf_pkg::REG_MIN_INT:    r_min_int     <= i_cfg_data[FW-1:0];
                fpdf_pkg::REG_GROUP:      r_group       <= i_cfg_data[FW-1:0];
                fpdf_pkg::REG_SEP_CHAR:   r_sep_char    <= i_cfg_data[CW-1:0];
                fpdf_pkg::REG_PERIOD:     r_period_char <= i_cfg_data[CW-1:0];
                fpdf_pkg::REG_MODE:       r_mode        <= i_cfg_data[fpdf_pkg::MODE_W-1:0];
                fpdf_pkg::REG_THRESH:     r_thresh      <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // output ports; character truncated or zero-extended to CHAR_BITS
    assign w_code_ext  = {{CHAR_BITS{1'b0}}, r_char};
    assign o_char_code = w_code_ext[CHAR_BITS-1:0];
    assign o_strobe    = r_strobe;
    assign o_last      = r_last;

endmodule

// ===== design/fpdf_bcd_cell.sv =====
// ----------------------------------------------------------------------------
// fpdf_bcd_cell
// One BCD digit of the shift-and-add-3 row: adjusts its digit, shifts in
// the bit from the lower neighbor and hands its top bit to the upper one.
// ----------------------------------------------------------------------------
module fpdf_bcd_cell (
    input  logic                i_clk,
    input  fpdf_pkg::t_chain_ctl i_ctl,
    input  logic                i_carry,
    output logic                o_carry,
    output fpdf_pkg::t_digit    o_digit
);

    fpdf_pkg::t_digit r_digit;
    fpdf_pkg::t_digit n_digit;
    fpdf_pkg::t_digit w_adj;

    // add 3 when the digit would overflow past 9 after doubling
    always_comb begin
        w_adj = (r_digit >= 4'd5) ? r_digit + 4'd3 : r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.shift) begin
            n_digit = {w_adj[2:0], i_carry};
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

endmodule

// ===== design/fpdf_bcd_chain.sv =====
// ----------------------------------------------------------------------------
// fpdf_bcd_chain
// Row of BCD cells converting the magnitude, one bit per shift, MSB first.
// ----------------------------------------------------------------------------
module fpdf_bcd_chain (
    input  logic                 i_clk,
    input  fpdf_pkg::t_chain_ctl i_ctl,
    output fpdf_pkg::t_digits    o_digits
);

    logic [fpdf_pkg::NUM_BCD-2:0] w_carry;

    genvar k;
    generate
        for (k = 0; k < fpdf_pkg::NUM_BCD; k++) begin : g_cell
            logic w_cin;
            if (k == 0) begin : g_lsd
                assign w_cin = i_ctl.bit_in;
            end else begin : g_mid
                assign w_cin = w_carry[k-1];
            end

            if (k == fpdf_pkg::NUM_BCD - 1) begin : g_msd
                // top digit: 2^64 fits in NUM_BCD digits, carry is never set
                fpdf_bcd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (i_ctl),
                    .i_carry (w_cin),
                    .o_carry (),
                    .o_digit (o_digits[k])
                );
            end else begin : g_low
                fpdf_bcd_cell u_cell (
                    .i_clk   (i_clk),
                    .i_ctl   (i_ctl),
                    .i_carry (w_cin),
                    .o_carry (w_carry[k]),
                    .o_digit (o_digits[k])
                );
            end
        end
    endgenerate

endmodule

// ===== design/fpdf_checker.sv =====
// ----------------------------------------------------------------------------
// fpdf_checker
// Port-level checks on the formatter's command and result behavior.
// ----------------------------------------------------------------------------
module fpdf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic o_strobe,
    input logic o_last
);

    // a taken item keeps the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after start");

    // conversion comes first, so no character right after a start
    a_no_char_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("character right after start");

    // more characters follow a non-final one, so the block is still busy
    a_busy_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("idle in the middle of a text");

    // the final character is never followed directly by another
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("character right after the final one");

    // configuration is taken only while idle
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |-> !busy)
        else $error("configuration taken while busy");

endmodule

bind fixed_point_decimal_formatter fpdf_checker u_fpdf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .o_strobe    (o_strobe),
    .o_last      (o_last)
);

// ===== tb/fpdf_text_checker.sv =====
// ----------------------------------------------------------------------------
// fpdf_text_checker
// Watches the formatter's item, register and character channels. Keeps its
// own copy of the format registers, works out the decimal text of each
// accepted value and compares every emitted character, in order, with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module fpdf_text_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_busy,
    input  logic [fpdf_pkg::VALUE_W-1:0]         i_value,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [fpdf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fpdf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_strobe,
    input  logic [fpdf_pkg::DEF_CHAR_BITS-1:0]   i_char_code,
    input  logic                                 i_last,
    output int                                   o_pending,
    output int                                   o_fail_count
);

    localparam int DIGIT_ROW    = 40;
    localparam int INT_DIGITS   = fpdf_pkg::DEF_MAX_INT_DIGITS;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [fpdf_pkg::CODE_W-1:0] code;
        logic                        last;
    } t_text_char;

    // shadow of the format registers
    logic [fpdf_pkg::FIELD_W-1:0]  fmt_scale_exp;
    logic [fpdf_pkg::FIELD_W-1:0]  fmt_frac_digits;
    logic [fpdf_pkg::FIELD_W-1:0]  fmt_min_int;
    logic [fpdf_pkg::FIELD_W-1:0]  fmt_group;
    logic [fpdf_pkg::CODE_W-1:0]   fmt_sep;
    logic [fpdf_pkg::CODE_W-1:0]   fmt_period;
    logic [fpdf_pkg::MODE_W-1:0]   fmt_mode;
    logic [fpdf_pkg::THRESH_W-1:0] fmt_thresh;

    t_text_char expected_text [$];
    int         mismatches = 0;

    function automatic logic [63:0] ten_pow(input int k);
        logic [63:0] r;
        int          j;
        r = 64'd1;
        for (j = 0; j < k; j++) r = r * 64'd10;
        return r;
    endfunction

    // build the text of one raw value and queue its characters
    function automatic void predict_text(input logic [fpdf_pkg::VALUE_W-1:0] raw);
        logic                        negative;
        logic [63:0]                 mag;
        logic [63:0]                 scale;
        logic [63:0]                 int_part;
        logic [63:0]                 frac_part;
        int                          exp_eff;
        int                          frac_eff;
        int                          min_eff;
        int                          n_digits;
        int                          total;
        int                          d;
        int                          i;
        int                          k;
        logic [3:0]                  digit_row [DIGIT_ROW];
        logic [fpdf_pkg::CODE_W-1:0] text [$];

        negative = raw[fpdf_pkg::VALUE_W-1];
        mag      = negative ? (~raw + 64'd1) : raw;
        exp_eff  = (fmt_scale_exp > fpdf_pkg::MAX_EXPONENT) ? fpdf_pkg::MAX_EXPONENT
                                                            : int'(fmt_scale_exp);
        frac_eff = (fmt_frac_digits > fpdf_pkg::MAX_FRAC_DIGITS) ? fpdf_pkg::MAX_FRAC_DIGITS
                                                                 : int'(fmt_frac_digits);
        min_eff  = (fmt_min_int > INT_DIGITS) ? INT_DIGITS : int'(fmt_min_int);
        scale     = ten_pow(exp_eff);
        int_part  = mag / scale;
        frac_part = mag % scale;

        // integer digits, least significant first
        n_digits = 0;
        while (int_part != 0 && n_digits < DIGIT_ROW) begin
            digit_row[n_digits] = 4'(int_part % 64'd10);
            int_part = int_part / 64'd10;
            n_digits++;
        end
        total = (n_digits > min_eff) ? n_digits : min_eff;

        if (negative) begin
            text.push_back(fpdf_pkg::CH_MINUS);
        end else if (fmt_mode[fpdf_pkg::MODE_PLUS]) begin
            text.push_back(fpdf_pkg::CH_PLUS);
        end

        // padded, grouped integer part
        for (i = total - 1; i >= 0; i--) begin
            d = (i < n_digits) ? int'(digit_row[i]) : 0;
            text.push_back(fpdf_pkg::CODE_W'(fpdf_pkg::CH_ZERO + d));
            if (i != 0 && fmt_group != 0 && (i % int'(fmt_group)) == 0)
                text.push_back(fmt_sep);
        end

        // truncated fraction, zeros past the exponent
        if ((frac_eff != 0 || fmt_mode[fpdf_pkg::MODE_FORCE_PERIOD]) &&
            (fmt_thresh == 0 || mag < {33'd0, fmt_thresh}) &&
            (fmt_mode[fpdf_pkg::MODE_FORCE_FRAC] || frac_part != 0)) begin
            text.push_back(fmt_period);
            for (k = 0; k < frac_eff; k++) begin
                d = (k < exp_eff) ?
                    int'((frac_part / ten_pow(exp_eff - 1 - k)) % 64'd10) : 0;
                text.push_back(fpdf_pkg::CODE_W'(fpdf_pkg::CH_ZERO + d));
            end
        end

        foreach (text[j])
            expected_text.push_back('{code: text[j], last: (j == text.size() - 1)});
    endfunction

    // register writes, prediction and comparison on each clock edge
    always @(posedge i_clk) begin
        t_text_char want;
        if (!i_rst_n) begin
            fmt_scale_exp   <= '0;
            fmt_frac_digits <= '0;
            fmt_min_int     <= fpdf_pkg::RST_MIN_INT;
            fmt_group       <= '0;
            fmt_sep         <= fpdf_pkg::RST_SEP_CHAR;
            fmt_period      <= fpdf_pkg::RST_PERIOD;
            fmt_mode        <= fpdf_pkg::RST_MODE;
            fmt_thresh      <= '0;
            expected_text.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fpdf_pkg::REG_SCALE_EXP:
                        fmt_scale_exp   <= i_cfg_data[fpdf_pkg::FIELD_W-1:0];
                    fpdf_pkg::REG_FRAC_DIGIT:
                        fmt_frac_digits <= i_cfg_data[fpdf_pkg::FIELD_W-1:0];
                    fpdf_pkg::REG_MIN_INT:
                        fmt_min_int     <= i_cfg_data[fpdf_pkg::FIELD_W-1:0];
                    fpdf_pkg::REG_GROUP:
                        fmt_group       <= i_cfg_data[fpdf_pkg::FIELD_W-1:0];
                    fpdf_pkg::REG_SEP_CHAR:
                        fmt_sep         <= i_cfg_data[fpdf_pkg::CODE_W-1:0];
                    fpdf_pkg::REG_PERIOD:
                        fmt_period      <= i_cfg_data[fpdf_pkg::CODE_W-1:0];
                    fpdf_pkg::REG_MODE:
                        fmt_mode        <= i_cfg_data[fpdf_pkg::MODE_W-1:0];
                    fpdf_pkg::REG_THRESH:
                        fmt_thresh      <= i_cfg_data[fpdf_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy)
                predict_text(i_value);
            if (i_strobe) begin
                if (expected_text.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("[%0t] unexpected char: code %h last %b",
                                 $time, i_char_code, i_last);
                    mismatches++;
                end else begin
                    want = expected_text.pop_front();
                    if (i_char_code !== want.code || i_last !== want.last) begin
                        if (mismatches < REPORT_LIMIT)
                            $display("[%0t] char mismatch: expected %h last %b, got %h last %b",
                                     $time, want.code, want.last, i_char_code, i_last);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= expected_text.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_fixed_point_decimal_formatter.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_decimal_formatter
// Drives raw fixed-point values and format register settings into the
// formatter: a directed set of edge values and formats first, then random
// formats and values under changing sender gaps. The checker beside the
// block predicts and compares every character; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_fixed_point_decimal_formatter;

    localparam int CLK_HALF           = 2;
    localparam int RESET_CYCLES       = 10;
    localparam int SETTLE_CYCLES      = 160;
    localparam int CYCLE_LIMIT        = 400000;
    localparam int FORMATS_PER_REGIME = 4;
    localparam int ITEMS_PER_FORMAT   = 17;

    localparam logic [fpdf_pkg::VALUE_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [fpdf_pkg::VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [fpdf_pkg::FIELD_W-1:0]  scale_exp;
        logic [fpdf_pkg::FIELD_W-1:0]  frac_digits;
        logic [fpdf_pkg::FIELD_W-1:0]  min_int;
        logic [fpdf_pkg::FIELD_W-1:0]  group;
        logic [fpdf_pkg::CODE_W-1:0]   sep;
        logic [fpdf_pkg::CODE_W-1:0]   period;
        logic [fpdf_pkg::MODE_W-1:0]   mode;
        logic [fpdf_pkg::THRESH_W-1:0] thresh;
    } t_format;

    logic                                i_clk     = 1'b0;
    logic                                i_rst_n   = 1'b0;
    logic                                start     = 1'b0;
    logic signed [fpdf_pkg::VALUE_W-1:0] value     = '0;
    logic                                cfg_valid = 1'b0;
    logic [fpdf_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [fpdf_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;
    logic                                busy;
    logic                                cfg_ready;
    logic                                strobe;
    logic [fpdf_pkg::DEF_CHAR_BITS-1:0]  char_code;
    logic                                char_last;
    int                                  pending_chars;
    int                                  fail_count;
    int                                  cycle_count     = 0;
    int                                  sender_idle_pct = 0;

    fixed_point_decimal_formatter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (value),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_strobe    (strobe),
        .o_char_code (char_code),
        .o_last      (char_last)
    );

    fpdf_text_checker u_text_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (value),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_strobe     (strobe),
        .i_char_code  (char_code),
        .i_last       (char_last),
        .o_pending    (pending_chars),
        .o_fail_count (fail_count)
    );

    // clock
    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [fpdf_pkg::MODE_W-1:0] mode_bits(input logic plus,
                                                              input logic force_period,
                                                              input logic force_frac);
        logic [fpdf_pkg::MODE_W-1:0] m;
        m                              = '0;
        m[fpdf_pkg::MODE_PLUS]         = plus;
        m[fpdf_pkg::MODE_FORCE_PERIOD] = force_period;
        m[fpdf_pkg::MODE_FORCE_FRAC]   = force_frac;
        return m;
    endfunction

    // mostly legal ranges, now and then the clamped top of the exponent, fraction digit and padding fields
    function automatic t_format random_format();
        t_format f;
        f.scale_exp   = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 20))
                                                 : 5'($urandom_range(19));
        f.frac_digits = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 19))
                                                 : 5'($urandom_range(18));
        f.min_int     = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 21))
                                                 : 5'($urandom_range(20));
        case ($urandom_range(3))
            0:       f.group = '0;
            1:       f.group = 5'($urandom_range(4, 1));
            2:       f.group = 5'($urandom_range(31, 1));
            default: f.group = 5'd3;
        endcase
        f.sep    = fpdf_pkg::CODE_W'($urandom);
        f.period = fpdf_pkg::CODE_W'($urandom);
        f.mode   = fpdf_pkg::MODE_W'($urandom_range(7));
        case ($urandom_range(2))
            0:       f.thresh = '0;
            1:       f.thresh = fpdf_pkg::THRESH_W'($urandom_range(100000, 1));
            default: f.thresh = fpdf_pkg::THRESH_W'($urandom);
        endcase
        return f;
    endfunction

    // full-range, small, scale-aligned, shortened and extreme values
    function automatic logic [fpdf_pkg::VALUE_W-1:0] random_value(
        input logic [fpdf_pkg::FIELD_W-1:0] scale_exp);
        logic [63:0] mag;
        int          j;
        case ($urandom_range(4))
            0: return {$urandom, $urandom};
            1: mag = 64'($urandom_range(99999));
            2: begin
                mag = 64'd1;
                for (j = 0; j < scale_exp && j < fpdf_pkg::MAX_EXPONENT; j++)
                    mag = mag * 64'd10;
                mag = mag * 64'($urandom_range(999));
            end
            3: mag = {$urandom, $urandom} >> $urandom_range(63);
            default: begin
                case ($urandom_range(3))
                    0:       return VAL_MAX;
                    1:       return VAL_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
        endcase
        return $urandom_range(1) ? -mag : mag;
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_chars != 0);
    endtask

    // valid stays up across back-to-back writes
    task automatic write_reg(input logic [fpdf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fpdf_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // block idle first: all text out, then room for an item with empty text
    task automatic apply_format(input t_format f);
        start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(fpdf_pkg::REG_SCALE_EXP,  fpdf_pkg::CFG_DATA_W'(f.scale_exp));
        write_reg(fpdf_pkg::REG_FRAC_DIGIT, fpdf_pkg::CFG_DATA_W'(f.frac_digits));
        write_reg(fpdf_pkg::REG_MIN_INT,    fpdf_pkg::CFG_DATA_W'(f.min_int));
        write_reg(fpdf_pkg::REG_GROUP,      fpdf_pkg::CFG_DATA_W'(f.group));
        write_reg(fpdf_pkg::REG_SEP_CHAR,   fpdf_pkg::CFG_DATA_W'(f.sep));
        write_reg(fpdf_pkg::REG_PERIOD,     fpdf_pkg::CFG_DATA_W'(f.period));
        write_reg(fpdf_pkg::REG_MODE,       fpdf_pkg::CFG_DATA_W'(f.mode));
        write_reg(fpdf_pkg::REG_THRESH,     fpdf_pkg::CFG_DATA_W'(f.thresh));
        cfg_valid <= 1'b0;
    endtask

    // one item; in each cycle start drops with the sender's idle share
    task automatic send_value(input logic [fpdf_pkg::VALUE_W-1:0] v);
        logic go;
        value <= v;
        do begin
            go = (sender_idle_pct == 0) || ($urandom_range(99) >= sender_idle_pct);
            start <= go;
            @(posedge i_clk);
        end while (!(go && !busy));
    endtask

    // stimulus and verdict
    initial begin
        t_format fmt;
        int      regime;
        int      fmt_n;
        int      n;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register values after reset
        send_value('0);
        send_value(64'd1);
        send_value('1);
        send_value(VAL_MAX);
        send_value(VAL_MIN);

        // widest text: full padding, group of one, all flags
        apply_format('{scale_exp: 5'd18, frac_digits: 5'd18, min_int: 5'd20, group: 5'd1,
                       sep: 16'hFFFF, period: 16'hFFFF, mode: mode_bits(1, 1, 1),
                       thresh: '0});
        send_value('0);
        send_value(VAL_MIN);
        send_value(VAL_MAX);
        send_value(64'd1000000000000000000);
        send_value(-64'sd123456789);

        // clamped exponent, fraction digits and padding; top threshold
        apply_format('{scale_exp: 5'd31, frac_digits: 5'd31, min_int: 5'd31, group: 5'd31,
                       sep: '0, period: '0, mode: mode_bits(1, 1, 0),
                       thresh: '1});
        send_value('0);
        send_value(VAL_MIN);
        send_value(64'd12345);
        send_value(64'h0000_0000_7FFF_FFFF);

        // empty text, threshold edge, fraction digits past the exponent
        apply_format('{scale_exp: 5'd3, frac_digits: 5'd18, min_int: '0, group: '0,
                       sep: 16'h002C, period: fpdf_pkg::RST_PERIOD,
                       mode: mode_bits(0, 0, 0), thresh: 31'd1000});
        send_value('0);
        send_value(64'd999);
        send_value(64'd1000);
        send_value(-64'sd2000);
        send_value(64'd1234567);

        // zero grouping with full padding; period alone
        apply_format('{scale_exp: 5'd2, frac_digits: '0, min_int: 5'd20, group: '0,
                       sep: 16'h005F, period: fpdf_pkg::RST_PERIOD,
                       mode: mode_bits(0, 1, 0), thresh: '0});
        send_value(64'd5);
        send_value(-64'sd123456);
        send_value(64'd100);

        // random formats and values under three sender gap regimes
        for (regime = 0; regime < 3; regime++) begin
            sender_idle_pct = (regime == 0) ? 26 : (regime == 1) ? 66 : 0;
            for (fmt_n = 0; fmt_n < FORMATS_PER_REGIME; fmt_n++) begin
                fmt = random_format();
                apply_format(fmt);
                for (n = 0; n < ITEMS_PER_FORMAT; n++) begin
                    // now and then hold off until the text is all out
                    if ($urandom_range(29) == 0) begin
                        start <= 1'b0;
                        wait_drained();
                    end
                    send_value(random_value(fmt.scale_exp));
                end
            end
        end

        start <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
